// File: hw/rtl/euler_scale_joint_matrix_assert.svh
// assertion macros for the joint matrix block
// expects clk and rst in the scope that uses them
`ifndef EULER_SCALE_JOINT_MATRIX_ASSERT_SVH
`define EULER_SCALE_JOINT_MATRIX_ASSERT_SVH

// consequent checked in the same cycle
`define ESJM_AST_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define ESJM_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/esjm_pkg.sv
// shared types and constants for the joint matrix pipeline
// no dependencies
package esjm_pkg;

  localparam int SIN_LAT = 7;
  localparam int QUO_W   = 25;
  localparam int ENT_LAT = QUO_W + 3;

  localparam logic [3:0] RULE_SSC = 4'd2;
  localparam int         FLAG_SSC = 0;

  localparam logic [23:0] OUT_MAX = 24'h7FFFFF;
  localparam logic [23:0] OUT_MIN = 24'h800000;

  // quarter-wave sine, odd terms, Q30
  localparam logic signed [31:0] SIN_COEF [6] = '{
    32'sd1686629713, -32'sd693598668, 32'sd85569306,
    -32'sd5026995, 32'sd172273, -32'sd3864
  };

  typedef struct packed {
    logic [23:0] val;
    logic        sat;
  } ent_res_t;

endpackage

// File: hw/rtl/esjm_sine.sv
// pipelined quarter-wave sine on a 17-bit phase, Q1.15 out
// depends on esjm_pkg
module esjm_sine (
  input  logic               clk,
  input  logic               en,
  input  logic [16:0]        phase,
  output logic signed [16:0] value
);

  function automatic logic signed [31:0] horner(input logic signed [31:0] acc,
                                                input logic [30:0] w,
                                                input logic signed [31:0] coef);
    logic signed [63:0] prod;
    logic signed [63:0] rnd;
    prod = 64'(acc) * 64'($signed({1'b0, w}));
    rnd  = (prod + 64'sd536870912) >>> 30;
    return 32'(rnd + 64'(coef));
  endfunction

  logic [15:0]        vv;
  logic [30:0]        w_q [5];
  logic [15:0]        v_q [6];
  logic               n_q [6];
  logic signed [31:0] acc_q [5];
  logic signed [63:0] fin_prod;
  logic signed [63:0] fin_rnd;
  logic [16:0]        mag;

  // mirror the second and fourth quarter
  assign vv = phase[15] ? 16'(17'd32768 - 17'(phase[14:0])) : 16'(phase[14:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      w_q[0] <= 31'(32'(vv) * 32'(vv));
      v_q[0] <= vv;
      n_q[0] <= phase[16];
    end
  end

  for (genvar h = 0; h < 5; h++) begin : g_horner
    logic signed [31:0] acc_in;
    if (h == 0) begin : g_first
      assign acc_in = esjm_pkg::SIN_COEF[5];
    end else begin : g_next
      assign acc_in = acc_q[h-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        acc_q[h]  <= horner(acc_in, w_q[h], esjm_pkg::SIN_COEF[4-h]);
        v_q[h+1]  <= v_q[h];
        n_q[h+1]  <= n_q[h];
      end
    end
    if (h < 4) begin : g_w
      always_ff @(posedge clk) begin
        if (en) begin
          w_q[h+1] <= w_q[h];
        end
      end
    end
  end

  always_comb begin
    fin_prod = 64'(acc_q[4]) * 64'($signed({1'b0, v_q[5]}));
    fin_rnd  = (fin_prod + 64'sd536870912) >>> 30;
    if (fin_rnd < 64'sd0) begin
      mag = 17'd0;
    end else if (fin_rnd > 64'sd32768) begin
      mag = 17'd32768;
    end else begin
      mag = fin_rnd[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value <= n_q[5] ? $signed(17'(-mag)) : $signed(mag);
    end
  end

endmodule

// File: hw/rtl/esjm_entry.sv
// one matrix entry: rounding, optional divide by parent scale, clamp
// depends on esjm_pkg; quotient pipeline one bit a stage
module esjm_entry #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [57:0]  prod,
  input  logic signed [23:0]  parent,
  input  logic                comp,
  output esjm_pkg::ent_res_t  res
);

  localparam int K  = 30 - FRAC_BITS;
  localparam int QW = esjm_pkg::QUO_W;

  typedef struct packed {
    logic [23:0]        p;
    logic               neg;
    logic               comp;
    logic               ovf;
    esjm_pkg::ent_res_t nc;
  } ctl_t;

  logic signed [57:0] nc_rnd;
  esjm_pkg::ent_res_t nc_d;
  logic [57:0]        un1;
  logic [23:0]        p1;
  logic               neg1;
  logic               comp1;
  esjm_pkg::ent_res_t nc1;
  logic [58:0]        np;
  logic [58:0]        rem [QW];
  logic [QW-1:0]      quo [QW+1];
  ctl_t               ctl [QW+1];

  // plain path: round half up from Q30
  always_comb begin
    nc_rnd = (prod + 58'sd536870912) >>> 30;
    if (nc_rnd > 58'sd8388607) begin
      nc_d = '{val: esjm_pkg::OUT_MAX, sat: 1'b1};
    end else if (nc_rnd < -58'sd8388608) begin
      nc_d = '{val: esjm_pkg::OUT_MIN, sat: 1'b1};
    end else begin
      nc_d = '{val: nc_rnd[23:0], sat: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      un1   <= prod[57] ? 58'(-prod) : 58'(prod);
      p1    <= parent[23] ? 24'(-parent) : 24'(parent);
      neg1  <= prod[57] ^ parent[23];
      comp1 <= comp;
      nc1   <= nc_d;
    end
  end

  // half the divisor added, then the power-of-two part of the divisor shifted out
  assign np = (59'(un1) + (59'(p1) << (K - 1))) >> K;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= np;
      quo[0] <= '0;
      ctl[0] <= '{p: p1, neg: neg1, comp: comp1,
                  ovf: ((np >> QW) >= 59'(p1)), nc: nc1};
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_bit
    logic [58:0] dv;
    logic        ge;
    assign dv = 59'(ctl[j].p) << (QW - 1 - j);
    assign ge = rem[j] >= dv;
    always_ff @(posedge clk) begin
      if (en) begin
        quo[j+1] <= {quo[j][QW-2:0], ge};
        ctl[j+1] <= ctl[j];
      end
    end
    if (j < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j+1] <= ge ? rem[j] - dv : rem[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (!ctl[QW].comp) begin
        res <= ctl[QW].nc;
      end else if (ctl[QW].neg) begin
        if (ctl[QW].ovf || quo[QW] > 25'd8388608) begin
          res <= '{val: esjm_pkg::OUT_MIN, sat: 1'b1};
        end else begin
          res <= '{val: 24'(-quo[QW]), sat: 1'b0};
        end
      end else begin
        if (ctl[QW].ovf || quo[QW] > 25'd8388607) begin
          res <= '{val: esjm_pkg::OUT_MAX, sat: 1'b1};
        end else begin
          res <= '{val: quo[QW][23:0], sat: 1'b0};
        end
      end
    end
  end

endmodule

// File: hw/rtl/euler_scale_joint_matrix.sv
// euler x-y-z rotation-scale matrix, top level
// depends on esjm_pkg, esjm_sine, esjm_entry and the assertion header
//
//   port group  dir  contents
//   cfg_*       in   scaling rule write, 4 bits
//   s_axis      in   angles, scales, parent scales, joint flags
//   m_axis      out  nine entries, zero parent flag, saturation flag
//
// one joint a cycle unless m_tready stalls the pipeline; the quotient pipeline in each
// entry yields one quotient bit a stage
// rst clears the valid bits and the scaling rule only
// m_tready low while m_tvalid is high freezes every stage together, so nothing is lost or repeated
`include "euler_scale_joint_matrix_assert.svh"

module euler_scale_joint_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // angle_x, angle_y, angle_z (16 each), scale_x/y/z, parent_scale_x/y/z (24 each),
  // joint_flags (8)
  input  logic [199:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // col0_row0 .. col2_row2 (24 each, column major), zero_parent_scale, saturated,
  // 6 zero bits
  output logic [223:0] m_tdata
);

  localparam int ENT_LAT = esjm_pkg::ENT_LAT;
  localparam int LAT     = 1 + esjm_pkg::SIN_LAT + 3 + ENT_LAT + 1;
  localparam logic [23:0] USE_MIN = 24'((64'd1 << FRAC_BITS) / 64'd1000000);

  typedef struct packed {
    logic [2:0][23:0] sc;
    logic [2:0][23:0] ps;
    logic             comp;
    logic             zf;
  } side_t;

  function automatic logic signed [33:0] rs15(input logic signed [49:0] x);
    logic signed [49:0] t;
    t = (x + 50'sd16384) >>> 15;
    return 34'(t);
  endfunction

  logic [3:0]          scaling_rule;
  logic                en;
  logic [LAT-1:0]      vld;

  logic [15:0]         ang [3];
  logic [16:0]         mag [3];
  logic [17:0]         dbl [3];
  logic [17:0]         xs [3];
  logic [1:0]          qd [3];
  logic [17:0]         ph [3];
  logic [17:0]         sph [3];
  logic [23:0]         pa [3];
  logic [2:0]          usable;
  logic                want;
  side_t               side_in;

  logic [16:0]         ph_s [3];
  logic [16:0]         ph_c [3];
  side_t               side_q [10];
  logic signed [16:0]  sn [3];
  logic signed [16:0]  cs [3];

  logic signed [31:0]  m_sxcz, m_cxsz, m_sxsz, m_cxcz;
  logic signed [31:0]  r0_q, r1_q, r2_q, r5_q, r8_q;
  logic signed [16:0]  sy_q;
  logic signed [33:0]  rot_q [9];
  logic signed [57:0]  prod_q [9];
  logic signed [23:0]  ps_q [3];
  logic                comp_q;
  logic                zf_q;
  logic [ENT_LAT-1:0]  zp;
  esjm_pkg::ent_res_t  res [9];
  logic [8:0]          sat_vec;
  logic [23:0]         out_val [9];
  logic                out_z;
  logic                out_sat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scaling_rule <= 4'd0;
    end else if (cfg_valid) begin
      scaling_rule <= cfg_data;
    end
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // phase = round(|a| * 65536 / 32767) as 2|a| plus a quotient of 0, 1 or 2
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ang[i] = s_tdata[16*i +: 16];
      mag[i] = ang[i][15] ? 17'(-{ang[i][15], ang[i]}) : {1'b0, ang[i]};
      dbl[i] = {mag[i], 1'b0};
      xs[i]  = dbl[i] + 18'd16383;
      qd[i]  = (xs[i] >= 18'd65534) ? 2'd2 : ((xs[i] >= 18'd32767) ? 2'd1 : 2'd0);
      ph[i]  = dbl[i] + 18'(qd[i]);
      sph[i] = ang[i][15] ? 18'(-ph[i]) : ph[i];
      side_in.sc[i] = s_tdata[48 + 24*i +: 24];
      side_in.ps[i] = s_tdata[120 + 24*i +: 24];
      pa[i]  = side_in.ps[i][23] ? 24'(-side_in.ps[i]) : side_in.ps[i];
      usable[i] = pa[i] > USE_MIN;
    end
    want = (scaling_rule == esjm_pkg::RULE_SSC) && s_tdata[192 + esjm_pkg::FLAG_SSC];
    side_in.comp = want && (&usable);
    side_in.zf   = want && !(&usable);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ph_s[i] <= sph[i][16:0];
        ph_c[i] <= sph[i][16:0] + 17'h08000;
      end
      side_q[0] <= side_in;
      for (int j = 1; j < 10; j++) begin
        side_q[j] <= side_q[j-1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_trig
    esjm_sine u_sin (.clk(clk), .en(en), .phase(ph_s[i]), .value(sn[i]));
    esjm_sine u_cos (.clk(clk), .en(en), .phase(ph_c[i]), .value(cs[i]));
  end

  // pairwise products, Q30
  always_ff @(posedge clk) begin
    if (en) begin
      m_sxcz <= 32'(sn[0]) * 32'(cs[2]);
      m_cxsz <= 32'(cs[0]) * 32'(sn[2]);
      m_sxsz <= 32'(sn[0]) * 32'(sn[2]);
      m_cxcz <= 32'(cs[0]) * 32'(cs[2]);
      r0_q   <= 32'(cs[1]) * 32'(cs[2]);
      r1_q   <= 32'(sn[2]) * 32'(cs[1]);
      r2_q   <= -(32'(sn[1]) <<< 15);
      r5_q   <= 32'(sn[0]) * 32'(cs[1]);
      r8_q   <= 32'(cs[1]) * 32'(cs[0]);
      sy_q   <= sn[1];
    end
  end

  // three-factor terms in Q45, rounded back to Q30
  always_ff @(posedge clk) begin
    if (en) begin
      rot_q[0] <= 34'(r0_q);
      rot_q[1] <= 34'(r1_q);
      rot_q[2] <= 34'(r2_q);
      rot_q[3] <= rs15(50'(m_sxcz) * 50'(sy_q) - (50'(m_cxsz) <<< 15));
      rot_q[4] <= rs15(50'(m_sxsz) * 50'(sy_q) + (50'(m_cxcz) <<< 15));
      rot_q[5] <= 34'(r5_q);
      rot_q[6] <= rs15(50'(m_cxcz) * 50'(sy_q) + (50'(m_sxsz) <<< 15));
      rot_q[7] <= rs15(50'(m_cxsz) * 50'(sy_q) - (50'(m_sxcz) <<< 15));
      rot_q[8] <= 34'(r8_q);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          prod_q[c*3+r] <= 58'($signed(side_q[9].sc[c])) * 58'(rot_q[c*3+r]);
        end
      end
      for (int r = 0; r < 3; r++) begin
        ps_q[r] <= side_q[9].ps[r];
      end
      comp_q <= side_q[9].comp;
      zf_q   <= side_q[9].zf;
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_ent
    esjm_entry #(.FRAC_BITS(FRAC_BITS)) u_ent (
      .clk    (clk),
      .en     (en),
      .prod   (prod_q[k]),
      .parent (ps_q[k % 3]),
      .comp   (comp_q),
      .res    (res[k])
    );
    assign sat_vec[k] = res[k].sat;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zp <= {zp[ENT_LAT-2:0], zf_q};
      for (int k = 0; k < 9; k++) begin
        out_val[k] <= res[k].val;
      end
      out_z   <= zp[ENT_LAT-1];
      out_sat <= |sat_vec;
    end
  end

  always_comb begin
    m_tdata = '0;
    for (int k = 0; k < 9; k++) begin
      m_tdata[24*k +: 24] = out_val[k];
    end
    m_tdata[216] = out_z;
    m_tdata[217] = out_sat;
  end

  `ESJM_AST_NEXT(a_take, s_tvalid && s_tready, vld[0], "accepted request not captured")
  `ESJM_AST_NEXT(a_hold, !en, $stable(vld), "pipeline advanced during stall")
  `ESJM_AST_SAME(a_zero, vld[10] && zf_q, !comp_q, "zero parent flag with division on")
  `ESJM_AST_NEXT(a_rule, cfg_valid, scaling_rule == $past(cfg_data), "rule write lost")

endmodule
